/* hdl/awning_motor_mode_controller_defines.svh */
// ----------------------------------------------------------------------------
// Awning controller assertion macros
// Shared property forms for the checker of the awning mode controller.
// ----------------------------------------------------------------------------
`ifndef AWNING_MOTOR_MODE_CONTROLLER_DEFINES_SVH
`define AWNING_MOTOR_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, reset masked.
`define AMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, reset masked.
`define AMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

/* hdl/amc_pkg.sv */
// ----------------------------------------------------------------------------
// amc_pkg
// Types and constants of the awning motor mode controller.
// ----------------------------------------------------------------------------
package amc_pkg;

  localparam int unsigned CFG_W  = 16;
  localparam int unsigned TIME_W = 16;

  typedef enum logic [2:0] {
    MODE_OFF        = 3'd0,
    MODE_AUTO       = 3'd1,
    MODE_MANUAL     = 3'd2,
    MODE_MOVING     = 3'd3,
    MODE_RETRACTING = 3'd4
  } amc_mode_e;

  typedef enum logic {
    CFG_BLINK_PERIOD = 1'b0,
    CFG_BLINK_ON     = 1'b1
  } amc_cfg_idx_e;

  localparam logic [CFG_W-1:0] BLINK_PERIOD_RST = 16'd200;
  localparam logic [CFG_W-1:0] BLINK_ON_RST     = 16'd100;

  // bit positions in the stored button levels
  localparam int unsigned BTN_EXTEND  = 0;
  localparam int unsigned BTN_RETRACT = 1;

  typedef struct packed {
    logic              power_switch;
    logic              auto_select;
    logic              limit_inner;
    logic              limit_outer;
    logic              sunshine;
    logic              button_extend;
    logic              button_retract;
    logic [TIME_W-1:0] time_ms;
  } amc_scan_t;

  typedef struct packed {
    logic       lamp_power;
    logic       lamp_automatic;
    logic       lamp_manual;
    logic       motor_retract;
    logic       motor_extend;
    logic [2:0] mode_code;
  } amc_result_t;

endpackage

/* hdl/awning_motor_mode_controller.sv */
// ----------------------------------------------------------------------------
// awning_motor_mode_controller
// Sun-awning mode controller: one scan in, one lamp/motor/mode result out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one scan request: switch
//   levels, button levels and a millisecond timestamp. Output channel
//   (out_valid_o / out_stall_i) returns one result per scan: lamps, motor
//   drives and the mode code after the scan.
//   From acceptance to out_valid_o a scan passes the input register, which the
//   accepting edge loads, and then the result register, which takes the mode
//   and timer update once the output stage is free to load it.
//   Throughput is one scan per cycle while the receiver does not stall; the
//   mode/flag/timer state is a single register set, updated per accepted scan.
//   While the receiver stalls, the result holds and one more scan may wait
//   in the input register; after that in_stall_o rises.
//   Reset brings the mode to off, clears all held flags and the button
//   history, and loads the blink registers with 200 ms period and 100 ms on.
//   Write the blink registers through cfg_we_i only while no scan is in flight.
// ----------------------------------------------------------------------------
module awning_motor_mode_controller
  import amc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              power_switch_i,
  input  logic              auto_select_i,
  input  logic              limit_inner_i,
  input  logic              limit_outer_i,
  input  logic              sunshine_i,
  input  logic              button_extend_i,
  input  logic              button_retract_i,
  input  logic [TIME_W-1:0] time_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              lamp_power_o,
  output logic              lamp_automatic_o,
  output logic              lamp_manual_o,
  output logic              motor_retract_o,
  output logic              motor_extend_o,
  output logic [2:0]        mode_code_o
);

  logic [CFG_W-1:0] blink_period_q, blink_on_q;
  amc_scan_t        scan_in, scan_reg;
  amc_result_t      res_d, res_q;
  logic             scan_vld, out_ready, adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q <= BLINK_PERIOD_RST;
      blink_on_q     <= BLINK_ON_RST;
    end else if (cfg_we_i) begin
      case (amc_cfg_idx_e'(cfg_index_i))
        CFG_BLINK_PERIOD: blink_period_q <= cfg_wdata_i;
        CFG_BLINK_ON:     blink_on_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    scan_in.power_switch   = power_switch_i;
    scan_in.auto_select    = auto_select_i;
    scan_in.limit_inner    = limit_inner_i;
    scan_in.limit_outer    = limit_outer_i;
    scan_in.sunshine       = sunshine_i;
    scan_in.button_extend  = button_extend_i;
    scan_in.button_retract = button_retract_i;
    scan_in.time_ms        = time_ms_i;
  end

  assign adv = scan_vld && out_ready;

  amc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .scan_i     (scan_in),
    .adv_i      (adv),
    .scan_vld_o (scan_vld),
    .scan_o     (scan_reg)
  );

  amc_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .scan_i         (scan_reg),
    .blink_period_i (blink_period_q),
    .blink_on_i     (blink_on_q),
    .result_o       (res_d)
  );

  amc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .result_i    (res_d),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res_q)
  );

  assign lamp_power_o     = res_q.lamp_power;
  assign lamp_automatic_o = res_q.lamp_automatic;
  assign lamp_manual_o    = res_q.lamp_manual;
  assign motor_retract_o  = res_q.motor_retract;
  assign motor_extend_o   = res_q.motor_extend;
  assign mode_code_o      = res_q.mode_code;

endmodule

/* hdl/amc_in_stage.sv */
// ----------------------------------------------------------------------------
// amc_in_stage
// Input register for one scan request, with its valid flag.
// ----------------------------------------------------------------------------
module amc_in_stage
  import amc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  amc_scan_t scan_i,
  input  logic      adv_i,
  output logic      scan_vld_o,
  output amc_scan_t scan_o
);

  logic      vld_q, vld_d;
  amc_scan_t scan_q;
  logic      accept;

  // hold off new requests only while the held scan cannot move on
  assign in_stall_o = vld_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign vld_d      = accept || (vld_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      scan_q <= scan_i;
    end
  end

  assign scan_vld_o = vld_q;
  assign scan_o     = scan_q;

endmodule

/* hdl/amc_core.sv */
// ----------------------------------------------------------------------------
// amc_core
// Mode state machine, held lamp and motor flags and the manual blink timer.
// ----------------------------------------------------------------------------
module amc_core
  import amc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  amc_scan_t        scan_i,
  input  logic [CFG_W-1:0] blink_period_i,
  input  logic [CFG_W-1:0] blink_on_i,
  output amc_result_t      result_o
);

  localparam int unsigned CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

  amc_mode_e             mode_q, mode_d, pmode;
  logic [1:0]            btn_q, btn_d, edges;
  logic                  dr_q, dr_d, de_q, de_d;
  logic                  al_q, al_d, ml_q, ml_d, ml_mode;
  logic                  be_q, be_d;
  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic [CMP_W-1:0]      now_ext;
  logic [TIME_WIDTH-1:0] now, elapsed, elapsed2;
  logic                  restart;
  logic                  power, autosel, inner, outer, sun;

  assign power   = scan_i.power_switch;
  assign autosel = scan_i.auto_select;
  assign inner   = scan_i.limit_inner;
  assign outer   = scan_i.limit_outer;
  assign sun     = scan_i.sunshine;

  assign btn_d = {scan_i.button_retract, scan_i.button_extend};
  assign edges = btn_d & ~btn_q;

  assign now_ext = CMP_W'(scan_i.time_ms);
  assign now     = now_ext[TIME_WIDTH-1:0];

  // power loss or an unfinished retract overrides the current mode
  always_comb begin
    pmode = mode_q;
    if ((!power && (mode_q != MODE_OFF)) || (mode_q == MODE_RETRACTING)) begin
      pmode = inner ? MODE_OFF : MODE_RETRACTING;
    end
  end

  // next mode
  always_comb begin
    case (pmode)
      MODE_AUTO: begin
        mode_d = autosel ? MODE_AUTO : MODE_MANUAL;
        if ((inner && sun) || (outer && !sun)) begin
          mode_d = MODE_MOVING;
        end
      end
      MODE_MANUAL: begin
        mode_d = autosel ? MODE_AUTO : MODE_MANUAL;
        if ((edges[BTN_EXTEND] && inner) || (edges[BTN_RETRACT] && outer)) begin
          mode_d = MODE_MOVING;
        end
      end
      MODE_MOVING: begin
        mode_d = MODE_MOVING;
        if ((dr_q || de_q) && ((inner && dr_q) || (outer && de_q))) begin
          mode_d = MODE_AUTO;
        end
      end
      MODE_RETRACTING: begin
        mode_d = MODE_RETRACTING;
      end
      default: begin
        mode_d = power ? MODE_AUTO : MODE_OFF;
      end
    endcase
  end

  // held flags per mode
  always_comb begin
    al_d    = al_q;
    ml_mode = ml_q;
    dr_d    = dr_q;
    de_d    = de_q;
    be_d    = be_q;
    case (pmode)
      MODE_AUTO: begin
        al_d    = 1'b1;
        ml_mode = 1'b0;
        dr_d    = 1'b0;
        de_d    = 1'b0;
        be_d    = 1'b0;
      end
      MODE_MANUAL: begin
        al_d = 1'b0;
        dr_d = 1'b0;
        de_d = 1'b0;
        be_d = 1'b1;
      end
      MODE_MOVING: begin
        // start a drive only from standstill, away from the reached end
        if (!dr_q && !de_q) begin
          de_d = inner;
          dr_d = !inner && outer;
        end
      end
      MODE_RETRACTING: begin
        al_d = 1'b0;
        dr_d = 1'b1;
        de_d = 1'b0;
        be_d = 1'b0;
      end
      default: begin
        al_d    = 1'b0;
        ml_mode = 1'b0;
        dr_d    = 1'b0;
        de_d    = 1'b0;
        be_d    = 1'b0;
      end
    endcase
  end

  // blink timer
  assign elapsed  = now - start_q;
  assign restart  = be_d && (CMP_W'(elapsed) >= CMP_W'(blink_period_i));
  assign elapsed2 = restart ? '0 : elapsed;

  always_comb begin
    start_d = now;
    ml_d    = ml_mode;
    if (be_d) begin
      start_d = restart ? now : start_q;
      if (restart) begin
        ml_d = 1'b1;
      end
      if (CMP_W'(elapsed2) >= CMP_W'(blink_on_i)) begin
        ml_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      btn_q   <= '0;
      dr_q    <= 1'b0;
      de_q    <= 1'b0;
      al_q    <= 1'b0;
      ml_q    <= 1'b0;
      be_q    <= 1'b0;
      start_q <= '0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      btn_q   <= btn_d;
      dr_q    <= dr_d;
      de_q    <= de_d;
      al_q    <= al_d;
      ml_q    <= ml_d;
      be_q    <= be_d;
      start_q <= start_d;
    end
  end

  always_comb begin
    result_o.lamp_power     = (pmode != MODE_OFF);
    result_o.lamp_automatic = al_d;
    result_o.lamp_manual    = ml_d;
    result_o.motor_retract  = dr_d;
    result_o.motor_extend   = de_d;
    result_o.mode_code      = mode_d;
  end

endmodule

/* hdl/amc_out_stage.sv */
// ----------------------------------------------------------------------------
// amc_out_stage
// Result register with valid flag toward the receiver.
// ----------------------------------------------------------------------------
module amc_out_stage
  import amc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  amc_result_t result_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output amc_result_t result_o
);

  logic        vld_q, vld_d;
  amc_result_t res_q;

  // free when empty or when the held result leaves this cycle
  assign ready_o = !vld_q || !out_stall_i;
  assign vld_d   = load_i || (vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

/* hdl/amc_checker.sv */
// ----------------------------------------------------------------------------
// amc_checker
// Port-level checks of the awning controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "awning_motor_mode_controller_defines.svh"

module amc_checker
  import amc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       lamp_power_o,
  input logic       lamp_automatic_o,
  input logic       lamp_manual_o,
  input logic       motor_retract_o,
  input logic       motor_extend_o,
  input logic [2:0] mode_code_o
);

  `AMC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `AMC_ASSERT_IMPLY(a_no_dual_drive, clk_i, rst_ni, out_valid_o, !(motor_retract_o && motor_extend_o))
  `AMC_ASSERT_IMPLY(a_off_quiet, clk_i, rst_ni, out_valid_o && (mode_code_o == MODE_OFF), !motor_retract_o && !motor_extend_o && !lamp_automatic_o && !lamp_manual_o)
  `AMC_ASSERT_IMPLY(a_retract_drive, clk_i, rst_ni, out_valid_o && (mode_code_o == MODE_RETRACTING), motor_retract_o && !motor_extend_o && lamp_power_o)

endmodule

bind awning_motor_mode_controller amc_checker u_amc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .lamp_power_o     (lamp_power_o),
  .lamp_automatic_o (lamp_automatic_o),
  .lamp_manual_o    (lamp_manual_o),
  .motor_retract_o  (motor_retract_o),
  .motor_extend_o   (motor_extend_o),
  .mode_code_o      (mode_code_o)
);
